FILE: sv/ism_pkg.sv
// Shared constants, types and command/status structs for the interval set block.
// Used by the controller, datapath and top level of the block; depends on nothing.
`default_nettype none

package ism_pkg;

    localparam int MAX_RANGES = 32;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int SUM_W      = PAGE_BITS + CNT_W;
    localparam int ENTRY_W    = 2 * PAGE_BITS;
    localparam int FIELD_W    = 16;
    localparam int TOTAL_W    = 16;
    localparam int COUNT_W    = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [31:0] PAGE_MAX  = 32'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [63:0] TOTAL_SAT = 64'((64'd1 << TOTAL_W) - 64'd1);
    localparam logic [31:0] COUNT_SAT = 32'((64'd1 << COUNT_W) - 64'd1);

    localparam logic REG_PAGE_LIMIT = 1'b0;

    typedef logic [PAGE_BITS-1:0] page_t;

    typedef struct packed {
        page_t lo;
        page_t hi;
    } range_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic flush;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic last_entry;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/ism_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; has no package dependency.
`default_nettype none

module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     ren,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/ism_datapath.sv
// Datapath: range clamp, table RAM, scan/merge/compact logic, totals and result registers.
// Depends on ism_pkg and ism_ram; driven by ism_controller commands.
`default_nettype none

module ism_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ism_pkg::dp_cmd_t               cmd,
    output ism_pkg::dp_status_t                 status,
    input  wire logic [ism_pkg::FIELD_W-1:0]    first_page,
    input  wire logic [ism_pkg::FIELD_W-1:0]    last_page,
    input  wire logic [ism_pkg::FIELD_W-1:0]    page_limit,
    output logic      [ism_pkg::TOTAL_W-1:0]    total_pages,
    output logic      [ism_pkg::COUNT_W-1:0]    range_count,
    output logic                                dropped
);
    import ism_pkg::*;

    page_t              lo_reg, lo_next;
    page_t              hi_reg, hi_next;
    page_t              nlo_reg, nlo_next;
    page_t              nhi_reg, nhi_next;
    range_t             hold_reg, hold_next;
    logic               past_before_reg, past_before_next;
    logic               inserted_reg, inserted_next;
    logic               merged_reg, merged_next;
    logic               drop_reg, drop_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TOTAL_W-1:0] res_total_reg, res_total_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic               res_drop_reg, res_drop_next;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_drop_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    range_t             ram_wdata;
    logic               ram_ren;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    range_t             rd;

    page_t              clamp_lo, clamp_hi;
    logic [PAGE_BITS:0] rd_hi_plus1, hi_plus1, ent_len, new_len;
    logic               is_before, is_merge, full, drop_now, drop_fin, last_entry;
    logic [SUM_W-1:0]   sum_fin;
    logic [CNT_W-1:0]   cnt_fin;

    ism_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_RANGES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .ren  (ram_ren),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd = ram_rdata;

    always_comb begin
        logic [31:0] a32;
        logic [31:0] b32;
        logic [31:0] mp32;
        a32  = (first_page < last_page) ? 32'(first_page) : 32'(last_page);
        b32  = (first_page < last_page) ? 32'(last_page) : 32'(first_page);
        mp32 = 32'(page_limit);
        if (a32 < 32'd1) begin
            a32 = 32'd1;
        end
        if (b32 < a32) begin
            b32 = a32;
        end
        if (mp32 != 32'd0) begin
            if (a32 > mp32) a32 = mp32;
            if (b32 > mp32) b32 = mp32;
        end
        if (a32 > PAGE_MAX) a32 = PAGE_MAX;
        if (b32 > PAGE_MAX) b32 = PAGE_MAX;
        clamp_lo = a32[PAGE_BITS-1:0];
        clamp_hi = b32[PAGE_BITS-1:0];
    end

    assign rd_hi_plus1 = {1'b0, rd.hi} + (PAGE_BITS+1)'(1);
    assign hi_plus1    = {1'b0, hi_reg} + (PAGE_BITS+1)'(1);
    assign ent_len     = {1'b0, rd.hi} - {1'b0, rd.lo} + (PAGE_BITS+1)'(1);
    assign new_len     = {1'b0, nhi_reg} - {1'b0, nlo_reg} + (PAGE_BITS+1)'(1);
    assign is_before   = !past_before_reg && (rd_hi_plus1 < {1'b0, lo_reg});
    assign is_merge    = !is_before && !inserted_reg && ({1'b0, rd.lo} <= hi_plus1);
    assign full        = (cnt_reg == CNT_W'(MAX_RANGES));
    assign drop_now    = !merged_reg && full;
    assign drop_fin    = inserted_reg ? drop_reg : drop_now;
    assign last_entry  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg);
    assign sum_fin     = sum_reg + (drop_fin ? SUM_W'(0) : SUM_W'(new_len));
    assign cnt_fin     = drop_fin ? cnt_reg : (wr_idx_reg + CNT_W'(1));

    assign status.cnt_zero   = (cnt_reg == CNT_W'(0));
    assign status.last_entry = last_entry;

    assign ram_ren   = cmd.start || (cmd.scan && !last_entry);
    assign ram_raddr = cmd.start ? IDX_W'(0) : (rd_idx_reg + IDX_W'(1));
    assign ram_waddr = wr_idx_reg[IDX_W-1:0];

    always_comb begin
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        nlo_next         = nlo_reg;
        nhi_next         = nhi_reg;
        hold_next        = hold_reg;
        past_before_next = past_before_reg;
        inserted_next    = inserted_reg;
        merged_next      = merged_reg;
        drop_next        = drop_reg;
        rd_idx_next      = rd_idx_reg;
        wr_idx_next      = wr_idx_reg;
        cnt_next         = cnt_reg;
        sum_next         = sum_reg;
        res_total_next   = res_total_reg;
        res_count_next   = res_count_reg;
        res_drop_next    = res_drop_reg;
        ram_we           = 1'b0;
        ram_wdata        = '{lo: nlo_reg, hi: nhi_reg};

        if (cmd.start) begin
            lo_next          = clamp_lo;
            hi_next          = clamp_hi;
            nlo_next         = clamp_lo;
            nhi_next         = clamp_hi;
            past_before_next = 1'b0;
            inserted_next    = 1'b0;
            merged_next      = 1'b0;
            drop_next        = 1'b0;
            rd_idx_next      = IDX_W'(0);
            wr_idx_next      = CNT_W'(0);
            sum_next         = SUM_W'(0);
        end else if (cmd.scan) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
            if (is_before) begin
                sum_next    = sum_reg + SUM_W'(ent_len);
                wr_idx_next = wr_idx_reg + CNT_W'(1);
            end else if (is_merge) begin
                past_before_next = 1'b1;
                merged_next      = 1'b1;
                nlo_next         = (rd.lo < nlo_reg) ? rd.lo : nlo_reg;
                nhi_next         = (rd.hi > nhi_reg) ? rd.hi : nhi_reg;
            end else begin
                past_before_next = 1'b1;
                sum_next         = sum_reg + SUM_W'(ent_len);
                hold_next        = rd;
                if (!inserted_reg) begin
                    inserted_next = 1'b1;
                    drop_next     = drop_now;
                    ram_we        = !drop_now;
                    ram_wdata     = '{lo: nlo_reg, hi: nhi_reg};
                    if (!drop_now) wr_idx_next = wr_idx_reg + CNT_W'(1);
                end else begin
                    ram_we    = !drop_reg;
                    ram_wdata = hold_reg;
                    if (!drop_reg) wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
            end
        end else if (cmd.flush) begin
            ram_we    = !drop_fin;
            ram_wdata = inserted_reg ? hold_reg : '{lo: nlo_reg, hi: nhi_reg};
            cnt_next  = cnt_fin;
            res_drop_next  = drop_fin;
            res_total_next = (64'(sum_fin) > TOTAL_SAT) ? TOTAL_SAT[TOTAL_W-1:0]
                                                        : TOTAL_W'(sum_fin);
            res_count_next = (32'(cnt_fin) > COUNT_SAT) ? COUNT_SAT[COUNT_W-1:0]
                                                        : COUNT_W'(cnt_fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            past_before_reg <= 1'b0;
            inserted_reg    <= 1'b0;
            merged_reg      <= 1'b0;
            drop_reg        <= 1'b0;
            rd_idx_reg      <= '0;
            wr_idx_reg      <= '0;
        end else begin
            cnt_reg         <= cnt_next;
            past_before_reg <= past_before_next;
            inserted_reg    <= inserted_next;
            merged_reg      <= merged_next;
            drop_reg        <= drop_next;
            rd_idx_reg      <= rd_idx_next;
            wr_idx_reg      <= wr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        nlo_reg       <= nlo_next;
        nhi_reg       <= nhi_next;
        hold_reg      <= hold_next;
        sum_reg       <= sum_next;
        res_total_reg <= res_total_next;
        res_count_reg <= res_count_next;
        res_drop_reg  <= res_drop_next;
        if (cmd.load) begin
            out_total_reg <= res_total_reg;
            out_count_reg <= res_count_reg;
            out_drop_reg  <= res_drop_reg;
        end
    end

    assign total_pages = out_total_reg;
    assign range_count = out_count_reg;
    assign dropped     = out_drop_reg;

endmodule

`default_nettype wire

FILE: sv/ism_controller.sv
// Controller state machine: sequences accept, table scan, final write and result beat.
// Depends on ism_pkg; talks to ism_datapath through command and status structs.
`default_nettype none

module ism_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ism_pkg::dp_cmd_t          cmd,
    input  wire ism_pkg::dp_status_t  status
);
    import ism_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready   = (state_reg == S_IDLE);
    assign cmd.start = (state_reg == S_IDLE) && s_valid;
    assign cmd.scan  = (state_reg == S_SCAN);
    assign cmd.flush = (state_reg == S_FLUSH);
    assign cmd.load  = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = (m_valid_reg && !m_ready) || cmd.load;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = status.cnt_zero ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (status.last_entry) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (cmd.load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: sv/interval_set_merge_insert.sv
// Top level of the interval set block: APB register, controller and datapath.
// Depends on ism_pkg, ism_controller and ism_datapath.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_first_page, s_last_page
//   m_        out        m_valid/m_ready    m_total_pages, m_range_count, m_dropped
//   apb       in         psel/penable       paddr, pwdata, prdata (page limit at 0x0)
//
// The result beat is offered after the accepted input beat passes the scan, flush and result
// states, the scan doing one read of the table RAM per stored range before it.
// A new beat is accepted once the previous result sits in the output register.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result beat holds the block after the next item's scan completes.
`default_nettype none

module interval_set_merge_insert (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ism_pkg::FIELD_W-1:0]   s_first_page,
    input  wire logic [ism_pkg::FIELD_W-1:0]   s_last_page,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ism_pkg::TOTAL_W-1:0]   m_total_pages,
    output logic      [ism_pkg::COUNT_W-1:0]   m_range_count,
    output logic                               m_dropped,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ism_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ism_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ism_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import ism_pkg::*;

    logic [FIELD_W-1:0] page_limit_reg, page_limit_next;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_PAGE_LIMIT);

    always_comb begin
        page_limit_next = page_limit_reg;
        if (psel && penable && pwrite && reg_sel) begin
            page_limit_next = pwdata[FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= '0;
        end else begin
            page_limit_reg <= page_limit_next;
        end
    end

    assign prdata = reg_sel ? PDATA_W'(page_limit_reg) : PDATA_W'(0);

    ism_controller u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    ism_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .first_page (s_first_page),
        .last_page  (s_last_page),
        .page_limit (page_limit_reg),
        .total_pages(m_total_pages),
        .range_count(m_range_count),
        .dropped    (m_dropped)
    );

endmodule

`default_nettype wire
